>>> rtl/core/btc_pkg.sv
// Shared constants, types and register codes of the beat onset to clock ticks block.
package btc_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int TICKS_PER_BEAT = 24;
  localparam int TIME_BITS      = 32;

  localparam int THR_BITS      = 24;
  localparam int HOLD_BITS     = 20;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam int SUM_BITS = (TIME_BITS > HOLD_BITS) ? TIME_BITS : HOLD_BITS;

  localparam int CNT_BITS = 3;
  localparam logic [CNT_BITS-1:0] ONSET_SAT   = 3'd5;
  localparam logic [CNT_BITS-1:0] TICKS_AFTER = 3'd4;
  localparam logic [CNT_BITS-1:0] ONSET_MIN   = 3'd1;

  localparam longint unsigned TIME_MAX   = (64'd1 << TIME_BITS) - 64'd1;
  localparam longint unsigned SPAN_Q_MAX = TIME_MAX / TICKS_PER_BEAT;
  localparam int SPAN_R_MAX  = int'(TIME_MAX % TICKS_PER_BEAT);
  localparam int SPAN_Q_BITS = $clog2(SPAN_Q_MAX + 64'd1);
  localparam int SPAN_R_BITS = (TICKS_PER_BEAT > 1) ? $clog2(TICKS_PER_BEAT) : 1;

  localparam logic [THR_BITS-1:0]  RISING_RESET  = 24'd265271;
  localparam logic [THR_BITS-1:0]  FALLING_RESET = 24'd26527;
  localparam logic [HOLD_BITS-1:0] HOLDOFF_RESET = 20'd960;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RISING  = 2'd0,
    CFG_FALLING = 2'd1,
    CFG_HOLDOFF = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                     we;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] magnitude;
    logic                   above_rise;
    logic                   below_fall;
    logic [TIME_BITS-1:0]   frame;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } fifo_wr_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } fifo_rd_t;

endpackage

>>> rtl/core/btc_if.sv
// Valid/ready channel interfaces for samples in and results out.
interface btc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [btc_pkg::SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface btc_out_if;
  logic                            valid;
  logic                            ready;
  logic [btc_pkg::SAMPLE_BITS-1:0] magnitude;
  logic                            clock_tick;
  logic                            beat_active;

  modport source (output valid, output magnitude, output clock_tick, output beat_active,
                  input ready);
  modport sink (input valid, input magnitude, input clock_tick, input beat_active,
                output ready);
endinterface

>>> rtl/core/beat_onset_to_clock_ticks.sv
// Top level: beat onset detector driving a timing clock at TICKS_PER_BEAT ticks per beat.
// Takes one sample per clock cycle while the queue has room, returns one result per sample,
// in order. A sample passes the front end (magnitude and threshold compares) into a two-entry
// queue; the back end updates beat state and tick timing combinationally and registers the
// result. Tick period comes from running quotient and remainder counters of the onset
// spacing, so no divider is needed. The thresholds and holdoff are to be written through the
// cfg_ port by the user only while no sample is in flight; the block does not enforce it.
module beat_onset_to_clock_ticks (
  input  logic                              clk,
  input  logic                              rst_n,
  btc_in_if.sink                            in_ch,
  btc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [btc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [btc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  btc_pkg::cfg_wr_t  cfg;
  btc_pkg::fifo_wr_t fifo_wr;
  btc_pkg::fifo_rd_t fifo_rd;
  logic              fifo_full;
  logic              fifo_pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  btc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fifo_full (fifo_full),
    .fifo_wr   (fifo_wr),
    .in_ch     (in_ch)
  );

  btc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (fifo_wr),
    .pop   (fifo_pop),
    .full  (fifo_full),
    .rd    (fifo_rd)
  );

  btc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .rd     (fifo_rd),
    .pop    (fifo_pop),
    .out_ch (out_ch)
  );

endmodule

>>> rtl/core/btc_front.sv
// Front end: accept samples, take magnitude, compare with thresholds, stamp frame index.
module btc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  btc_pkg::cfg_wr_t          cfg,
  input  logic                      fifo_full,
  output btc_pkg::fifo_wr_t         fifo_wr,
  btc_in_if.sink                    in_ch
);

  logic [btc_pkg::THR_BITS-1:0]    rise_r;
  logic [btc_pkg::THR_BITS-1:0]    fall_r;
  logic [btc_pkg::TIME_BITS-1:0]   frame_r;
  logic [btc_pkg::SAMPLE_BITS-1:0] raw;
  logic [btc_pkg::SAMPLE_BITS-1:0] mag;
  logic                            push;

  assign raw  = btc_pkg::SAMPLE_BITS'(in_ch.sample_value);
  assign mag  = raw[btc_pkg::SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  assign push = in_ch.valid && !fifo_full;

  assign in_ch.ready = !fifo_full;

  always_comb begin
    fifo_wr.push            = push;
    fifo_wr.item.magnitude  = mag;
    fifo_wr.item.above_rise = btc_pkg::CMP_BITS'(mag) > btc_pkg::CMP_BITS'(rise_r);
    fifo_wr.item.below_fall = btc_pkg::CMP_BITS'(mag) < btc_pkg::CMP_BITS'(fall_r);
    fifo_wr.item.frame      = frame_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r  <= btc_pkg::RISING_RESET;
      fall_r  <= btc_pkg::FALLING_RESET;
      frame_r <= '0;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          btc_pkg::CFG_RISING:  rise_r <= cfg.data[btc_pkg::THR_BITS-1:0];
          btc_pkg::CFG_FALLING: fall_r <= cfg.data[btc_pkg::THR_BITS-1:0];
          default: ;
        endcase
      end
      if (push) begin
        frame_r <= frame_r + 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/btc_fifo.sv
// Short queue of classified samples between front end and back end.
module btc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  btc_pkg::fifo_wr_t wr,
  input  logic              pop,
  output logic              full,
  output btc_pkg::fifo_rd_t rd
);

  btc_pkg::item_t               mem_r [btc_pkg::FIFO_DEPTH];
  logic [btc_pkg::FIFO_AW-1:0]  wr_ptr_r;
  logic [btc_pkg::FIFO_AW-1:0]  rd_ptr_r;
  logic [btc_pkg::FIFO_CW-1:0]  count_r;
  logic                         do_push;
  logic                         do_pop;

  assign full     = count_r == btc_pkg::FIFO_CW'(btc_pkg::FIFO_DEPTH);
  assign rd.avail = count_r != '0;
  assign rd.item  = mem_r[rd_ptr_r];
  assign do_push  = wr.push && !full;
  assign do_pop   = pop && rd.avail;

  function automatic logic [btc_pkg::FIFO_AW-1:0] ptr_inc(input logic [btc_pkg::FIFO_AW-1:0] p);
    if (p == btc_pkg::FIFO_AW'(btc_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/btc_back.sv
// Back end: beat tracking, onset spacing, tick timing and the output register.
module btc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  btc_pkg::cfg_wr_t  cfg,
  input  btc_pkg::fifo_rd_t rd,
  output logic              pop,
  btc_out_if.source         out_ch
);

  logic [btc_pkg::HOLD_BITS-1:0]   holdoff_r;
  logic                            in_beat_r;
  logic [btc_pkg::CNT_BITS-1:0]    cnt_r;
  logic [btc_pkg::TIME_BITS-1:0]   earliest_r;
  logic [btc_pkg::SPAN_Q_BITS-1:0] span_q_r;
  logic [btc_pkg::SPAN_R_BITS-1:0] span_r_r;
  logic [btc_pkg::SPAN_Q_BITS-1:0] period_r;
  logic [btc_pkg::TIME_BITS-1:0]   rem_r;

  logic                            out_valid_r;
  logic [btc_pkg::SAMPLE_BITS-1:0] out_mag_r;
  logic                            out_tick_r;
  logic                            out_beat_r;

  logic                            onset;
  logic                            beat_end;
  logic                            new_period;
  logic                            tick;
  logic                            in_beat_nxt;
  logic [btc_pkg::CNT_BITS-1:0]    cnt_nxt;
  logic [btc_pkg::TIME_BITS-1:0]   earliest_nxt;
  logic [btc_pkg::SPAN_Q_BITS-1:0] period_nxt;
  logic [btc_pkg::TIME_BITS-1:0]   rem_cur;
  logic [btc_pkg::TIME_BITS-1:0]   rem_nxt;
  logic [btc_pkg::SPAN_Q_BITS-1:0] base_q;
  logic [btc_pkg::SPAN_R_BITS-1:0] base_r;
  logic [btc_pkg::SPAN_Q_BITS-1:0] span_q_nxt;
  logic [btc_pkg::SPAN_R_BITS-1:0] span_r_nxt;

  assign pop = rd.avail && (!out_valid_r || out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.magnitude   = out_mag_r;
  assign out_ch.clock_tick  = out_tick_r;
  assign out_ch.beat_active = out_beat_r;

  always_comb begin
    onset    = !in_beat_r && (rd.item.frame > earliest_r) && rd.item.above_rise;
    beat_end = in_beat_r && rd.item.below_fall;

    in_beat_nxt  = onset || (in_beat_r && !beat_end);
    cnt_nxt      = (onset && cnt_r < btc_pkg::ONSET_SAT) ? cnt_r + 1'b1 : cnt_r;
    earliest_nxt = beat_end
                 ? btc_pkg::TIME_BITS'(btc_pkg::SUM_BITS'(rd.item.frame)
                                       + btc_pkg::SUM_BITS'(holdoff_r))
                 : earliest_r;

    new_period = onset && cnt_nxt > btc_pkg::ONSET_MIN;
    period_nxt = new_period ? span_q_r : period_r;
    rem_cur    = new_period ? btc_pkg::TIME_BITS'(span_q_r) : rem_r;
    tick       = (rem_cur == '0) && cnt_nxt > btc_pkg::TICKS_AFTER;
    rem_nxt    = tick ? btc_pkg::TIME_BITS'(period_nxt) - 1'b1 : rem_cur - 1'b1;

    base_q = onset ? '0 : span_q_r;
    base_r = onset ? '0 : span_r_r;
    if (base_q == btc_pkg::SPAN_Q_BITS'(btc_pkg::SPAN_Q_MAX)
        && base_r == btc_pkg::SPAN_R_BITS'(btc_pkg::SPAN_R_MAX)) begin
      span_q_nxt = '0;
      span_r_nxt = '0;
    end else if (base_r == btc_pkg::SPAN_R_BITS'(btc_pkg::TICKS_PER_BEAT - 1)) begin
      span_q_nxt = base_q + 1'b1;
      span_r_nxt = '0;
    end else begin
      span_q_nxt = base_q;
      span_r_nxt = base_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_mag_r  <= rd.item.magnitude;
      out_tick_r <= tick;
      out_beat_r <= in_beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r   <= btc_pkg::HOLDOFF_RESET;
      in_beat_r   <= 1'b0;
      cnt_r       <= '0;
      earliest_r  <= '0;
      span_q_r    <= '0;
      span_r_r    <= '0;
      period_r    <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          btc_pkg::CFG_HOLDOFF: holdoff_r <= cfg.data[btc_pkg::HOLD_BITS-1:0];
          default: ;
        endcase
      end
      if (pop) begin
        in_beat_r  <= in_beat_nxt;
        cnt_r      <= cnt_nxt;
        earliest_r <= earliest_nxt;
        span_q_r   <= span_q_nxt;
        span_r_r   <= span_r_nxt;
        period_r   <= period_nxt;
        rem_r      <= rem_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= btc_pkg::ONSET_SAT)
    else $error("onset count beyond saturation");

  a_span_rem: assert property (@(posedge clk) disable iff (!rst_n)
    span_r_r <= btc_pkg::SPAN_R_BITS'(btc_pkg::TICKS_PER_BEAT - 1))
    else $error("span remainder out of range");

  a_tick_needs_beats: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tick_r |-> cnt_r > btc_pkg::TICKS_AFTER)
    else $error("tick before enough onsets");

  a_tick_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    pop && tick |=> rem_r == btc_pkg::TIME_BITS'(period_r) - 1'b1)
    else $error("tick countdown not rearmed from period");

endmodule
